### src/assert_macros.svh
// Assertion helper macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked during reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check: when cond holds, prop must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### src/adsr_pkg.sv
// Shared constants and types for the ADSR envelope generator.
// No dependencies.
package adsr_pkg;

   localparam int LEVEL_W   = 20;
   localparam int TRIG_W    = 12;
   localparam int ENV_W     = 12;
   localparam int OUT_SHIFT = 7;
   localparam int CSR_IDX_W = 3;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = 20'd524288;
   localparam logic [ENV_W-1:0]   ENV_MAX    = 12'd4095;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_GATE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_STEP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_STEP   = 3'd4;

   // Reset values of the configuration registers
   localparam logic [TRIG_W-1:0]  RST_GATE_THRESHOLD = 12'd2048;
   localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP    = 20'd3333;
   localparam logic [LEVEL_W-1:0] RST_DECAY_STEP     = 20'd0;
   localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL  = 20'd12800;
   localparam logic [LEVEL_W-1:0] RST_RELEASE_STEP   = 20'd0;

   typedef struct packed {
      logic [TRIG_W-1:0]  gate_threshold;
      logic [LEVEL_W-1:0] attack_step;
      logic [LEVEL_W-1:0] decay_step;
      logic [LEVEL_W-1:0] sustain_level;
      logic [LEVEL_W-1:0] release_step;
   } cfg_type;

endpackage

### src/adsr_csr.sv
// Configuration register file of the ADSR envelope generator.
// Depends on adsr_pkg.
module adsr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [adsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [adsr_pkg::LEVEL_W-1:0]    csr_data,
   output adsr_pkg::cfg_type               cfg
);

   adsr_pkg::cfg_type cfg_ff;
   adsr_pkg::cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Index decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            adsr_pkg::REG_GATE_THRESHOLD:
               cfg_in.gate_threshold = csr_data[adsr_pkg::TRIG_W-1:0];
            adsr_pkg::REG_ATTACK_STEP:   cfg_in.attack_step   = csr_data;
            adsr_pkg::REG_DECAY_STEP:    cfg_in.decay_step    = csr_data;
            adsr_pkg::REG_SUSTAIN_LEVEL: cfg_in.sustain_level = csr_data;
            adsr_pkg::REG_RELEASE_STEP:  cfg_in.release_step  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_threshold <= adsr_pkg::RST_GATE_THRESHOLD;
         cfg_ff.attack_step    <= adsr_pkg::RST_ATTACK_STEP;
         cfg_ff.decay_step     <= adsr_pkg::RST_DECAY_STEP;
         cfg_ff.sustain_level  <= adsr_pkg::RST_SUSTAIN_LEVEL;
         cfg_ff.release_step   <= adsr_pkg::RST_RELEASE_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/adsr_envelope_generator.sv
// An accepted trigger item is registered in the input register; its envelope update
// then enters the result register once that register is free, which a stall can delay.
// Throughput: one item per cycle when not stalled; the level feedback is one add/compare step.
// Reset (synchronous): config returns to defaults, phase idle, level zero,
// both pipeline registers empty.
// Depends on adsr_pkg, adsr_csr and assert_macros.svh.
`include "assert_macros.svh"

module adsr_envelope_generator (
   input  logic                           clock,
   input  logic                           reset,
   // Trigger stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,  // [11:0] trigger_sample
   // Envelope stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,  // [11:0] envelope
   // Configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [adsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [adsr_pkg::LEVEL_W-1:0]   csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   localparam int LW          = adsr_pkg::LEVEL_W;
   localparam int OUT_SHIFT_C = adsr_pkg::OUT_SHIFT;

   adsr_pkg::cfg_type cfg;

   adsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   logic                          s1_valid_ff;
   logic [adsr_pkg::TRIG_W-1:0]   trig_ff;
   logic                          rsp_valid_ff;
   logic [adsr_pkg::ENV_W-1:0]    env_ff;
   logic [LW-1:0]                 level_ff, level_in;
   phase_type                     phase_ff, phase_in;
   logic                          gate_on_ff, gate_on_in;
   logic [adsr_pkg::ENV_W-1:0]    env_in;

   logic                          advance;
   logic                          req_accept;
   logic                          high;
   logic [LW-1:0]                 sus;
   phase_type                     phase_gated;
   logic [LW:0]                   attack_sum;
   logic [LW:0]                   decay_limit;
   logic [LW-OUT_SHIFT_C-1:0]     env_wide;

   // Pipeline handshake: stage 1 moves on when the result register frees up
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - adsr_pkg::ENV_W){1'b0}}, env_ff};

   // Envelope step for the item in stage 1
   always_comb begin
      high = trig_ff >= cfg.gate_threshold;
      sus  = (cfg.sustain_level > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE
                                                          : cfg.sustain_level;

      // Gate edges first
      phase_gated = phase_ff;
      gate_on_in  = gate_on_ff;
      if (high && !gate_on_ff) begin
         phase_gated = PH_ATTACK;
         gate_on_in  = 1'b1;
      end
      if (!high && gate_on_ff) begin
         phase_gated = PH_RELEASE;
         gate_on_in  = 1'b0;
      end

      attack_sum  = {1'b0, level_ff} + {1'b0, cfg.attack_step};
      decay_limit = {1'b0, sus} + {1'b0, cfg.decay_step};

      level_in = level_ff;
      phase_in = phase_gated;
      case (phase_gated)
         PH_ATTACK: begin
            if (level_ff >= adsr_pkg::FULL_SCALE) begin
               phase_in = PH_DECAY;
            end else if (attack_sum > {1'b0, adsr_pkg::FULL_SCALE}) begin
               level_in = adsr_pkg::FULL_SCALE;
            end else begin
               level_in = attack_sum[LW-1:0];
            end
         end
         PH_DECAY: begin
            // Snap to sustain once the next step would reach it
            if ({1'b0, level_ff} <= decay_limit) begin
               level_in = sus;
               phase_in = PH_SUSTAIN;
            end else begin
               level_in = level_ff - cfg.decay_step;
            end
         end
         PH_RELEASE: begin
            if (level_ff >= cfg.release_step) begin
               level_in = level_ff - cfg.release_step;
            end else begin
               level_in = '0;
               phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase

      // Output scaling with saturation at full scale
      env_wide = level_in[LW-1:OUT_SHIFT_C];
      if (env_wide > {1'b0, adsr_pkg::ENV_MAX}) begin
         env_in = adsr_pkg::ENV_MAX;
      end else begin
         env_in = env_wide[adsr_pkg::ENV_W-1:0];
      end
   end

   // State, pipeline control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         phase_ff     <= PH_IDLE;
         gate_on_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            level_ff     <= level_in;
            phase_ff     <= phase_in;
            gate_on_ff   <= gate_on_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         trig_ff <= req_tdata[adsr_pkg::TRIG_W-1:0];
      end
      if (advance) begin
         env_ff <= env_in;
      end
   end

   // Checks
   `ASSERT_ALWAYS(a_level_in_range, clock, reset, level_ff <= adsr_pkg::FULL_SCALE,
      "level above full scale")
   `ASSERT_ALWAYS(a_idle_at_zero, clock, reset, (phase_ff != PH_IDLE) || (level_ff == '0),
      "idle phase with nonzero level")
   `ASSERT_NEXT(a_sustain_holds, clock, reset, (phase_ff == PH_SUSTAIN),
      (phase_ff != PH_SUSTAIN) || $stable(level_ff), "level moved during sustain")
   `ASSERT_NEXT(a_stage1_held, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(trig_ff), "stalled stage 1 item lost or changed")

endmodule

### dv/envelope_check_pkg.sv
// Scoreboard for the ADSR envelope generator: tracks level, phase and gate
// per accepted trigger item and checks envelope items in order.
// Depends on adsr_pkg.
`timescale 1ns / 100ps

package envelope_check_pkg;
   import adsr_pkg::*;

   typedef enum logic [2:0] {
      ENV_IDLE    = 3'd0,
      ENV_ATTACK  = 3'd1,
      ENV_DECAY   = 3'd2,
      ENV_SUSTAIN = 3'd3,
      ENV_RELEASE = 3'd4
   } env_phase_e;

   localparam int REPORT_LIMIT = 10;

   class envelope_scoreboard;
      cfg_type           regs;
      logic [LEVEL_W-1:0] level;
      env_phase_e        phase;
      bit                gate_on;
      logic [ENV_W-1:0]  expected_env[$];
      int unsigned       mismatches;

      function new();
         regs.gate_threshold = RST_GATE_THRESHOLD;
         regs.attack_step    = RST_ATTACK_STEP;
         regs.decay_step     = RST_DECAY_STEP;
         regs.sustain_level  = RST_SUSTAIN_LEVEL;
         regs.release_step   = RST_RELEASE_STEP;
         level      = '0;
         phase      = ENV_IDLE;
         gate_on    = 1'b0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [LEVEL_W-1:0] data);
         case (idx)
            REG_GATE_THRESHOLD: regs.gate_threshold = data[TRIG_W-1:0];
            REG_ATTACK_STEP:    regs.attack_step    = data;
            REG_DECAY_STEP:     regs.decay_step     = data;
            REG_SUSTAIN_LEVEL:  regs.sustain_level  = data;
            REG_RELEASE_STEP:   regs.release_step   = data;
            default: ;
         endcase
      endfunction

      // One envelope step per trigger item: gate edges first, then the phase acts.
      function void note_trigger(logic [TRIG_W-1:0] trig);
         bit                 high;
         logic [31:0]        sus;
         logic [31:0]        sum;
         logic [LEVEL_W-8:0] shifted;
         logic [ENV_W-1:0]   env;
         high = (trig >= regs.gate_threshold);
         sus  = (regs.sustain_level > FULL_SCALE) ? 32'(FULL_SCALE)
                                                  : 32'(regs.sustain_level);
         if (high && !gate_on) begin
            phase   = ENV_ATTACK;
            gate_on = 1'b1;
         end
         if (!high && gate_on) begin
            phase   = ENV_RELEASE;
            gate_on = 1'b0;
         end
         case (phase)
            ENV_ATTACK: begin
               // at full scale hand over to decay without moving the level
               if (level >= FULL_SCALE) begin
                  phase = ENV_DECAY;
               end else begin
                  sum   = 32'(level) + 32'(regs.attack_step);
                  level = (sum > 32'(FULL_SCALE)) ? FULL_SCALE : sum[LEVEL_W-1:0];
               end
            end
            ENV_DECAY: begin
               // snap to sustain once the next step would reach it
               if (32'(level) <= sus + 32'(regs.decay_step)) begin
                  level = sus[LEVEL_W-1:0];
                  phase = ENV_SUSTAIN;
               end else begin
                  level = level - regs.decay_step;
               end
            end
            ENV_RELEASE: begin
               if (level >= regs.release_step) begin
                  level = level - regs.release_step;
               end else begin
                  level = '0;
                  phase = ENV_IDLE;
               end
            end
            default: ;
         endcase
         shifted = level[LEVEL_W-1:OUT_SHIFT];
         env     = (shifted > 13'(ENV_MAX)) ? ENV_MAX : shifted[ENV_W-1:0];
         expected_env.push_back(env);
      endfunction

      function void check_envelope(logic [ENV_W-1:0] actual);
         logic [ENV_W-1:0] want;
         if (expected_env.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("envelope item %0d with nothing outstanding", actual);
         end else begin
            want = expected_env.pop_front();
            if (actual !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("envelope mismatch: expected %0d, got %0d", want, actual);
            end
         end
      endfunction

      function int pending();
         return expected_env.size();
      endfunction
   endclass

endpackage

### dv/tb.sv
// Top of the ADSR envelope generator regression: drives trigger, envelope
// and register channels and checks every envelope item in order.
// Depends on adsr_pkg, envelope_check_pkg and the adsr_envelope_generator RTL.
`timescale 1ns / 100ps

module tb;
   import adsr_pkg::*;
   import envelope_check_pkg::*;

   localparam int DRAIN_CYCLES   = 4;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 170;
   localparam int QUIET_PHASE    = 4;
   localparam int IDLE_PERCENT   = 24;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [15:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEVEL_W-1:0]   csr_data;

   envelope_scoreboard sb = new();
   bit                 quiet_mode;
   logic [TRIG_W-1:0]  cur_threshold;
   int unsigned        cycle_count;

   adsr_envelope_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("adsr_envelope_generator regression: fail");
      $finish;
   end

   // Observe handshakes at the edge, before any driver update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_trigger(req_tdata[TRIG_W-1:0]);
         if (rsp_tvalid && rsp_tready) sb.check_envelope(rsp_tdata[ENV_W-1:0]);
      end
   end

   // Envelope side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= quiet_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_trigger(input logic [TRIG_W-1:0] trig);
      while (!quiet_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, trig};
      do @(posedge clock); while (!req_tready);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [LEVEL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [TRIG_W-1:0] thr,
                                input logic [LEVEL_W-1:0] att,
                                input logic [LEVEL_W-1:0] dec,
                                input logic [LEVEL_W-1:0] sus,
                                input logic [LEVEL_W-1:0] rel);
      write_csr(REG_GATE_THRESHOLD, LEVEL_W'(thr));
      write_csr(REG_ATTACK_STEP, att);
      write_csr(REG_DECAY_STEP, dec);
      write_csr(REG_SUSTAIN_LEVEL, sus);
      write_csr(REG_RELEASE_STEP, rel);
      csr_valid     <= 1'b0;
      cur_threshold  = thr;
   endtask

   // Lower valid, wait for every envelope item, then let the pipe settle.
   task automatic drain_envelopes();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [LEVEL_W-1:0] pick_step();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return FULL_SCALE;
         2:       return LEVEL_W'($urandom);
         3, 4, 5: return LEVEL_W'($urandom_range(1, 4000));
         default: return LEVEL_W'($urandom_range(4001, 120000));
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_sustain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return FULL_SCALE;
         2:       return LEVEL_W'($urandom_range(524289, 1048575));
         default: return LEVEL_W'($urandom_range(0, 524288));
      endcase
   endfunction

   function automatic logic [TRIG_W-1:0] pick_threshold();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 12'd4095;
         default: return TRIG_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // A trigger on the requested side of the threshold (threshold zero: always on)
   function automatic logic [TRIG_W-1:0] gate_sample(input bit want_high);
      if (want_high) return TRIG_W'($urandom_range(cur_threshold, 4095));
      if (cur_threshold == 0) return '0;
      return TRIG_W'($urandom_range(0, cur_threshold - 1));
   endfunction

   // Gate on for a while, then off, with some noise mixed in; stops at the phase quota
   task automatic send_gate_burst(inout int sent);
      int on_len;
      int off_len;
      on_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                            : $urandom_range(10, 250);
      off_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                            : $urandom_range(10, 120);
      for (int i = 0; i < on_len + off_len && sent < PHASE_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 8)
            send_trigger(TRIG_W'($urandom_range(0, 4095)));
         else
            send_trigger(gate_sample(i < on_len));
         sent++;
      end
   endtask

   initial begin
      int sent;
      reset      = 1'b1;
      quiet_mode = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      cur_threshold = RST_GATE_THRESHOLD;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: idle, attack on a rise, threshold itself counts as on,
      // release with a zero step holds the level
      send_trigger(12'd0);
      send_trigger(12'd4095);
      send_trigger(RST_GATE_THRESHOLD);
      send_trigger(RST_GATE_THRESHOLD - 12'd1);
      drain_envelopes();

      // One-step attack to full scale (saturated output), decay starts without
      // a level change, sustain above full scale, release below one step
      apply_setting(12'd4095, FULL_SCALE, 20'd100000, 20'hFFFFF, FULL_SCALE);
      repeat (4) send_trigger(12'd4095);
      repeat (3) send_trigger(12'd0);
      drain_envelopes();

      // Threshold zero keeps the gate on; a zero attack step never ends
      apply_setting(12'd0, 20'd0, 20'd0, 20'd0, 20'd0);
      send_trigger(12'd0);
      send_trigger(12'd4095);
      drain_envelopes();

      // Full cycle with sustain snap, retrigger from release, release to idle
      apply_setting(12'd2048, 20'd300000, 20'd50000, 20'd400000, 20'd150000);
      repeat (7) send_trigger(12'd4095);
      send_trigger(12'd2047);
      send_trigger(12'd2048);
      repeat (4) send_trigger(12'd0);
      drain_envelopes();

      // Random settings, mostly well-formed gate bursts
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_setting(pick_threshold(), pick_step(), pick_step(), pick_sustain(),
                       pick_step());
         quiet_mode = (p == QUIET_PHASE);
         sent = 0;
         while (sent < PHASE_ITEMS) send_gate_burst(sent);
         drain_envelopes();
      end
      quiet_mode = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("adsr_envelope_generator regression: pass");
      else
         $display("adsr_envelope_generator regression: fail");
      $finish;
   end

endmodule

### adsr_envelope_generator.f
+incdir+src
src/adsr_pkg.sv
src/adsr_csr.sv
src/adsr_envelope_generator.sv
dv/envelope_check_pkg.sv
dv/tb.sv
